// File: design/spg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spg_pkg - shared types and constants of the pulse generator
// Default widths, configuration register indexes and the
// command/status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package spg_pkg;

    localparam int SAMPLE_BITS_DEF   = 16;
    localparam int FRACTION_BITS_DEF = 8;
    localparam int PW_W              = 24;   // pulse_width register
    localparam int TIME_W            = 32;   // elapsed-time counter

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_WIDTH = 1'd1;

    // reset values of the configuration registers
    localparam int THRESHOLD_RST   = 3;
    localparam int PULSE_WIDTH_RST = 3072;

    typedef struct packed {
        logic load;        // capture the input sample
        logic trig;        // run the Schmitt trigger, set up the divider
        logic div_step;    // one restoring division step
        logic frac;        // apply the crossing fraction
        logic edge_eval;   // compare elapsed time with the pulse width
        logic mul;         // falling-edge interpolation product
        logic fin;         // final value, state update, result register
    } spg_cmd_t;

    typedef struct packed {
        logic div_need;    // a crossing that needs the divider
        logic out_free;    // result register can take a value this cycle
    } spg_sts_t;

endpackage

// File: design/spg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spg_if - stream channels of the pulse generator
// Valid/ready channels for the input sample and the pulse result.
// ----------------------------------------------------------------------------
interface spg_sample_if #(
    parameter int SAMPLE_BITS = spg_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface spg_pulse_if #(
    parameter int SAMPLE_BITS = spg_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-3:0] pulse_out;

    modport source (output valid, output pulse_out, input ready);
    modport sink   (input valid, input pulse_out, output ready);
endinterface

// File: design/spg_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spg_ctrl - sequencing controller
// Steps one sample through trigger, division, edge check and output.
// ----------------------------------------------------------------------------
module spg_ctrl #(
    parameter int FRACTION_BITS = spg_pkg::FRACTION_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output spg_pkg::spg_cmd_t cmd,
    input  spg_pkg::spg_sts_t sts
);
    import spg_pkg::*;

    localparam int CNT_W = $clog2(FRACTION_BITS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRACTION_BITS - 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_TRIG = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_FRAC = 3'd3;
    localparam logic [2:0] S_EVAL = 3'd4;
    localparam logic [2:0] S_MUL  = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_TRIG;
                end
            end
            S_TRIG:
            begin
                cmd.trig   = 1'b1;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (sts.div_need)
                begin
                    cmd.div_step = 1'b1;
                    cnt_next     = cnt_reg + 1'b1;
                    if (cnt_reg == CNT_LAST)
                    begin
                        state_next = S_FRAC;
                    end
                end
                else
                begin
                    state_next = S_FRAC;
                end
            end
            S_FRAC:
            begin
                cmd.frac   = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                cmd.edge_eval = 1'b1;
                state_next    = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (sts.out_free)
                begin
                    cmd.fin    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// File: design/spg_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spg_dp - pulse generator datapath
// Configuration and state registers, Schmitt trigger, restoring divider,
// edge interpolation multiplier and the result register.
// ----------------------------------------------------------------------------
module spg_dp #(
    parameter int SAMPLE_BITS   = spg_pkg::SAMPLE_BITS_DEF,
    parameter int FRACTION_BITS = spg_pkg::FRACTION_BITS_DEF,
    parameter int CFG_W         = spg_pkg::PW_W
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  spg_pkg::spg_cmd_t              cmd,
    output spg_pkg::spg_sts_t              sts,
    input  logic signed [SAMPLE_BITS-1:0]  sample_in,
    output logic signed [SAMPLE_BITS-3:0]  pulse_out,
    output logic                           out_valid,
    input  logic                           out_ready,
    input  logic                           cfg_we,
    input  logic [spg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]               cfg_data
);
    import spg_pkg::*;

    localparam int SB = SAMPLE_BITS;
    localparam int FB = FRACTION_BITS;
    localparam int VW = SAMPLE_BITS - 2;
    localparam logic [VW-1:0]     LEVEL_V     = VW'(2 ** (SB - 4));
    localparam logic [VW-1:0]     NEG_LEVEL_V = VW'(-(2 ** (SB - 4)));
    localparam logic [TIME_W-1:0] ONE_T       = TIME_W'(1) << FB;
    localparam logic [TIME_W-1:0] OFF_T       = '1;
    localparam logic [TIME_W-1:0] SAT_T       = OFF_T - ONE_T;
    localparam logic [FB:0]       ONE_Q       = (FB + 1)'(1) << FB;

    // configuration and item state
    logic [SB-2:0]       thr_reg;
    logic [PW_W-1:0]     pw_reg;
    logic                trig_high_reg;
    logic [TIME_W-1:0]   e_reg;
    logic signed [SB-1:0] prev_reg;
    logic signed [SB-1:0] x_reg;

    // per-item working registers
    logic                cross_reg;
    logic                div_need_reg;
    logic                interp_reg;
    logic                low_reg;
    logic [SB:0]         rem_reg;
    logic [SB:0]         den_reg;
    logic [FB:0]         q_reg;
    logic [VW-1:0]       val_reg;
    logic [FB:0]         d_reg;
    logic [VW+FB:0]      prod_reg;
    logic                out_valid_reg;
    logic [VW-1:0]       pulse_reg;

    logic signed [SB:0]  xe, pe, te, num, den;
    logic                go_low, go_high, short_div;
    logic [SB+1:0]       rem_dbl;
    logic                rem_fits;
    logic [FB+SB-3:0]    q_scaled;
    logic [VW-1:0]       val_frac;
    logic [TIME_W-1:0]   pw_ext, d_full;
    logic                e_ge, d_small;
    logic [VW-1:0]       val_pl;
    logic [VW+FB:0]      prod;
    logic [VW-1:0]       val_fin;
    logic [TIME_W-1:0]   e_mid, e_next;
    logic                out_free;

    // Schmitt trigger and divider set-up
    always_comb
    begin
        xe        = {x_reg[SB-1], x_reg};
        pe        = {prev_reg[SB-1], prev_reg};
        te        = $signed({2'b00, thr_reg});
        go_low    = trig_high_reg && (xe < -te);
        go_high   = !trig_high_reg && (xe > te);
        num       = xe - te;
        den       = xe - pe;
        short_div = (den <= num);
    end

    // restoring division step: remainder stays below the divisor
    assign rem_dbl  = {rem_reg, 1'b0};
    assign rem_fits = rem_dbl >= {1'b0, den_reg};

    // -LEVEL + 2*LEVEL*frac/ONE
    assign q_scaled = {q_reg, {(SB - 3){1'b0}}};
    assign val_frac = q_scaled[FB+SB-3:FB] + NEG_LEVEL_V;

    // falling edge
    assign pw_ext  = {{(TIME_W - PW_W){1'b0}}, pw_reg};
    assign e_ge    = e_reg >= pw_ext;
    assign d_full  = e_reg - pw_ext;
    assign d_small = d_full <= ONE_T;
    assign val_pl  = val_reg + LEVEL_V;
    assign prod    = (VW + FB + 1)'(val_pl) * (VW + FB + 1)'(d_reg);

    always_comb
    begin
        priority if (interp_reg)
        begin
            val_fin = val_reg - prod_reg[VW+FB-1:FB];
        end
        else if (low_reg)
        begin
            val_fin = NEG_LEVEL_V;
        end
        else
        begin
            val_fin = val_reg;
        end
        e_mid  = interp_reg ? OFF_T : e_reg;
        e_next = (e_mid > SAT_T) ? OFF_T : e_mid + ONE_T;
    end

    assign out_free     = !out_valid_reg || out_ready;
    assign sts.div_need = div_need_reg;
    assign sts.out_free = out_free;
    assign out_valid    = out_valid_reg;
    assign pulse_out    = $signed(pulse_reg);

    // control and persistent state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg       <= (SB - 1)'(THRESHOLD_RST);
            pw_reg        <= PW_W'(PULSE_WIDTH_RST);
            trig_high_reg <= 1'b0;
            e_reg         <= '0;
            prev_reg      <= '0;
            cross_reg     <= 1'b0;
            div_need_reg  <= 1'b0;
            interp_reg    <= 1'b0;
            low_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == CFG_THRESHOLD)
            begin
                thr_reg <= cfg_data[SB-2:0];
            end
            if (cfg_we && cfg_index == CFG_PULSE_WIDTH)
            begin
                pw_reg <= cfg_data[PW_W-1:0];
            end
            if (cmd.trig)
            begin
                if (go_low)
                begin
                    trig_high_reg <= 1'b0;
                end
                else if (go_high)
                begin
                    trig_high_reg <= 1'b1;
                end
                cross_reg    <= go_high;
                div_need_reg <= go_high && !short_div;
            end
            if (cmd.edge_eval)
            begin
                interp_reg <= e_ge && d_small;
                low_reg    <= e_ge && !d_small;
            end
            if (cmd.frac && cross_reg)
            begin
                e_reg <= {{(TIME_W - FB - 1){1'b0}}, q_reg};
            end
            else if (cmd.fin)
            begin
                e_reg <= e_next;
            end
            if (cmd.fin)
            begin
                prev_reg      <= x_reg;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg <= sample_in;
        end
        if (cmd.trig)
        begin
            rem_reg <= num;
            den_reg <= den;
            q_reg   <= short_div ? ONE_Q : '0;
            val_reg <= LEVEL_V;
        end
        if (cmd.div_step)
        begin
            rem_reg <= rem_fits ? rem_dbl[SB:0] - den_reg : rem_dbl[SB:0];
            q_reg   <= {q_reg[FB-1:0], rem_fits};
        end
        if (cmd.frac && cross_reg)
        begin
            val_reg <= val_frac;
        end
        if (cmd.edge_eval)
        begin
            d_reg <= d_full[FB:0];
        end
        if (cmd.mul)
        begin
            prod_reg <= prod;
        end
        if (cmd.fin)
        begin
            pulse_reg <= val_fin;
        end
    end

endmodule

// File: design/schmitt_pwm_pulse_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// schmitt_pwm_pulse_generator - Schmitt-triggered anti-aliased pulse source
// One signed sample in, one pulse sample out. Rising crossings of the
// hysteresis band start a pulse of programmable width; both edges are
// interpolated to the sub-sample crossing time.
// ----------------------------------------------------------------------------
//  channel   dir   payload                      beat
//  in_ch     in    sample_in  (SAMPLE_BITS s)   one audio sample
//  out_ch    out   pulse_out  (SAMPLE_BITS-2 s) one pulse sample
//  cfg_*     in    index / data                 one register write
//
//  An item passes through extra division steps when a rising crossing
//  needs the divider; the restoring divider produces one quotient bit
//  per cycle.
//  rst_n is asynchronous; it restores the register defaults and clears
//  the trigger, elapsed time and previous sample.
//  The result register lets a new sample be taken while the last result
//  waits; a stalled output holds the next item in its final step.
// ----------------------------------------------------------------------------
module schmitt_pwm_pulse_generator #(
    parameter int SAMPLE_BITS   = spg_pkg::SAMPLE_BITS_DEF,
    parameter int FRACTION_BITS = spg_pkg::FRACTION_BITS_DEF,
    parameter int CFG_W         = (SAMPLE_BITS - 1 > spg_pkg::PW_W) ?
                                  SAMPLE_BITS - 1 : spg_pkg::PW_W
) (
    input  logic                          clk,
    input  logic                          rst_n,
    spg_sample_if.sink                    in_ch,
    spg_pulse_if.source                   out_ch,
    input  logic                          cfg_we,
    input  logic [spg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]              cfg_data
);
    import spg_pkg::*;

    spg_cmd_t cmd;
    spg_sts_t sts;

    // Controller: sequences load, trigger, divide, edge check and output
    spg_ctrl #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .cmd      (cmd),
        .sts      (sts)
    );

    // Datapath: all arithmetic, the item state and the result register
    spg_dp #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .FRACTION_BITS (FRACTION_BITS),
        .CFG_W         (CFG_W)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .sample_in (in_ch.sample_in),
        .pulse_out (out_ch.pulse_out),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

// File: test/schmitt_pwm_pulse_generator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// schmitt_pwm_pulse_generator_tb - self-checking bench for the pulse generator
// Drives audio samples into the block, predicts every pulse sample with an
// independent model of the trigger, divider and edge interpolation, and
// compares each result beat with the oldest prediction. A short table of
// directed rows comes first, then waveform-shaped random samples under
// several register settings and idling patterns.
// ----------------------------------------------------------------------------
module schmitt_pwm_pulse_generator_tb;

    localparam int SMP_W  = spg_pkg::SAMPLE_BITS_DEF;
    localparam int FRAC_W = spg_pkg::FRACTION_BITS_DEF;
    localparam int OUT_W  = SMP_W - 2;
    localparam int THR_W  = SMP_W - 1;
    localparam int PW_W   = spg_pkg::PW_W;
    localparam int CFG_W  = (SMP_W - 1 > PW_W) ? SMP_W - 1 : PW_W;

    // pulse levels, time unit and the "off" value of the elapsed-time counter
    localparam longint PULSE_LEVEL = longint'(1) << (SMP_W - 4);
    localparam longint TIME_ONE    = longint'(1) << FRAC_W;
    localparam longint TIME_OFF    = 64'h0000_0000_FFFF_FFFF;

    localparam logic signed [OUT_W-1:0] PULSE_HI = OUT_W'(PULSE_LEVEL);
    localparam logic signed [OUT_W-1:0] PULSE_LO = OUT_W'(-PULSE_LEVEL);
    localparam logic signed [SMP_W-1:0] SMP_MAX  = {1'b0, {(SMP_W-1){1'b1}}};
    localparam logic signed [SMP_W-1:0] SMP_MIN  = {1'b1, {(SMP_W-1){1'b0}}};
    localparam logic [THR_W-1:0]        THR_MAX  = '1;
    localparam logic [PW_W-1:0]         PW_MAX   = '1;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 400;   // long receiver hold-off
    localparam int END_PAUSE   = 32;

    typedef enum logic { ROW_SAMPLE, ROW_WRITE } row_kind_t;

    typedef struct {
        row_kind_t                  kind;
        logic [spg_pkg::CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]           val;
        logic signed [SMP_W-1:0]    smp;
        bit                         typed;   // want below is read off by hand
        logic signed [OUT_W-1:0]    want;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic                          cfg_we;
    logic [spg_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]              cfg_data;

    spg_sample_if #(.SAMPLE_BITS(SMP_W)) sample_ch ();
    spg_pulse_if  #(.SAMPLE_BITS(SMP_W)) pulse_ch ();

    schmitt_pwm_pulse_generator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (sample_ch),
        .out_ch    (pulse_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // Pulse predictor: own copy of registers and state, block widths.
    // ------------------------------------------------------------------
    logic [THR_W-1:0]        thr_reg;
    logic [PW_W-1:0]         pw_reg;
    bit                      trig_hi;
    logic [31:0]             elapsed_t;
    logic signed [SMP_W-1:0] prev_smp;

    logic signed [OUT_W-1:0] pulse_expected[$];
    int                      mismatch_count;

    // typed expectation travelling alongside the sample beat
    bit                      row_typed;
    logic signed [OUT_W-1:0] row_want;
    logic signed [OUT_W-1:0] want_now;

    stim_row_t stim_table[$];

    int  src_idle_pct;
    int  sink_stall_pct;
    bit  hold_armed;
    bit  hold_taken;
    int  hold_left;
    int  cycle_count;

    // waveform generator state for the random part
    int  wave_val;
    int  wave_goal;
    int  wave_step;
    int  wave_sign;
    int  burst_left;
    int  burst_mode;

    function automatic void apply_config(input logic [spg_pkg::CFG_IDX_W-1:0] idx,
                                         input logic [CFG_W-1:0] data);
        case (idx)
            spg_pkg::CFG_THRESHOLD:   thr_reg = data[THR_W-1:0];   // upper bits dropped
            spg_pkg::CFG_PULSE_WIDTH: pw_reg  = data[PW_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic logic signed [OUT_W-1:0] predict_pulse(input logic signed [SMP_W-1:0] s);
        longint x, thr, pw, prv, e, val, num, den, frac, d;
        x   = s;
        thr = thr_reg;
        pw  = pw_reg;
        prv = prev_smp;
        e   = elapsed_t;
        val = PULSE_LEVEL;
        if (trig_hi && x < -thr) begin
            trig_hi = 1'b0;
        end
        else if (!trig_hi && x > thr) begin
            // rising crossing: fractional time past the crossing point
            trig_hi = 1'b1;
            num = x - thr;
            den = x - prv;
            // previous sample already at or above threshold: fraction clamps to one
            if (den <= num)
                frac = TIME_ONE;
            else
                frac = (num <<< FRAC_W) / den;
            e   = frac;
            val = -PULSE_LEVEL + ((2 * PULSE_LEVEL * frac) >>> FRAC_W);
        end
        if (e >= pw) begin
            d = e - pw;
            if (d <= TIME_ONE) begin
                // falling edge inside this sample: interpolate, then go off
                val = val - (((val + PULSE_LEVEL) * d) >>> FRAC_W);
                e   = TIME_OFF;
            end
            else begin
                val = -PULSE_LEVEL;
            end
        end
        prev_smp = s;
        // counter saturates at the off value, never wraps
        if (e > TIME_OFF - TIME_ONE)
            e = TIME_OFF;
        else
            e = e + TIME_ONE;
        elapsed_t = e[31:0];
        return val[OUT_W-1:0];
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        $display("[%0t] mismatch %0d: %s, got %0d, want %0d",
                 $realtime, mismatch_count, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // Directed table rows.
    // ------------------------------------------------------------------
    function automatic void row_smp(input logic signed [SMP_W-1:0] s);
        stim_row_t r;
        r = '{ROW_SAMPLE, '0, '0, s, 1'b0, '0};
        stim_table.push_back(r);
    endfunction

    function automatic void row_smp_exp(input logic signed [SMP_W-1:0] s,
                                        input logic signed [OUT_W-1:0] w);
        stim_row_t r;
        r = '{ROW_SAMPLE, '0, '0, s, 1'b1, w};
        stim_table.push_back(r);
    endfunction

    function automatic void row_wr(input logic [spg_pkg::CFG_IDX_W-1:0] i,
                                   input logic [CFG_W-1:0] v);
        stim_row_t r;
        r = '{ROW_WRITE, i, v, '0, 1'b0, '0};
        stim_table.push_back(r);
    endfunction

    // ------------------------------------------------------------------
    // Random sample shaping: mostly ramps swinging across the hysteresis
    // band, so the trigger and divider see real crossings; the rest is
    // full-range noise and samples sitting right on the thresholds.
    // ------------------------------------------------------------------
    function automatic int clamp_smp(input int v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    function automatic logic signed [SMP_W-1:0] next_sample();
        int thr;
        int gap;
        thr = thr_reg;
        if (burst_left == 0) begin
            burst_left = $urandom_range(4, 24);
            burst_mode = $urandom_range(0, 9);
        end
        burst_left--;
        if (burst_mode < 6) begin
            gap = wave_goal - wave_val;
            if (gap <= wave_step && gap >= -wave_step) begin
                wave_sign = -wave_sign;
                wave_goal = clamp_smp(wave_sign * (thr + $urandom_range(1, 3000)));
                wave_step = $urandom_range(1, 3000);
            end
            if (wave_goal > wave_val)
                wave_val = clamp_smp(wave_val + wave_step);
            else
                wave_val = clamp_smp(wave_val - wave_step);
            return SMP_W'(wave_val);
        end
        else if (burst_mode < 8) begin
            return SMP_W'($urandom);
        end
        else begin
            gap = $urandom_range(0, 6);
            if ($urandom_range(0, 1))
                return SMP_W'(clamp_smp(thr + gap - 3));
            return SMP_W'(clamp_smp(-thr + gap - 3));
        end
    endfunction

    // ------------------------------------------------------------------
    // Clock, timeout.
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL schmitt_pwm_pulse_generator");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus one long hold-off counted here so the
    // block fills up and pushes back on the sample channel.
    // ------------------------------------------------------------------
    initial
    begin
        pulse_ch.ready = 1'b0;
        hold_taken     = 1'b0;
        hold_left      = 0;
        forever
        begin
            @(posedge clk);
            if (hold_armed && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pulse_ch.ready <= 1'b0;
            end
            else
            begin
                pulse_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: everything sampled at the rising edge, before the block's
    // own updates land. Register writes feed the predictor's copy, each
    // sample beat pushes one prediction, each pulse beat pops one.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
                apply_config(cfg_index, cfg_data);
            if (pulse_ch.valid && pulse_ch.ready)
            begin
                if (pulse_expected.size() == 0)
                begin
                    report_mismatch("pulse beat with nothing pending", pulse_ch.pulse_out, 0);
                end
                else
                begin
                    want_now = pulse_expected.pop_front();
                    if (pulse_ch.pulse_out !== want_now)
                        report_mismatch("pulse_out", pulse_ch.pulse_out, want_now);
                end
            end
            if (sample_ch.valid && sample_ch.ready)
            begin
                // state always advances; a hand-typed row overrides the value
                want_now = predict_pulse(sample_ch.sample_in);
                if (row_typed)
                    pulse_expected.push_back(row_want);
                else
                    pulse_expected.push_back(want_now);
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender side.
    // ------------------------------------------------------------------
    task automatic offer_sample(input logic signed [SMP_W-1:0] s, input bit typed,
                                input logic signed [OUT_W-1:0] want);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sample_ch.valid     <= 1'b1;
        sample_ch.sample_in <= s;
        row_typed           <= typed;
        row_want            <= want;
        do
            @(posedge clk);
        while (!sample_ch.ready);
    endtask

    // stop offering and wait until every predicted beat has been seen
    task automatic settle_idle();
        sample_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pulse_expected.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [spg_pkg::CFG_IDX_W-1:0] idx,
                             input logic [CFG_W-1:0] val);
        settle_idle();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic shuffle_config();
        logic [THR_W-1:0] t;
        logic [PW_W-1:0]  p;
        case ($urandom_range(0, 7))
            0:       t = '0;
            1:       t = THR_MAX;
            2:       t = THR_W'($urandom);
            default: t = THR_W'($urandom_range(0, 1500));
        endcase
        case ($urandom_range(0, 7))
            0:       p = '0;
            1:       p = PW_MAX;
            2:       p = PW_W'($urandom);
            default: p = PW_W'($urandom_range(0, 6000));
        endcase
        // random junk above the threshold field must be ignored
        write_reg(spg_pkg::CFG_THRESHOLD, {(CFG_W - THR_W)'($urandom), t});
        write_reg(spg_pkg::CFG_PULSE_WIDTH, CFG_W'(p));
    endtask

    // two register settings per phase, half of the samples under each
    task automatic run_phase(input int src_pct, input int sink_pct, input int n_items);
        for (int half = 0; half < 2; half++)
        begin
            shuffle_config();
            src_idle_pct   = src_pct;
            sink_stall_pct = sink_pct;
            repeat (n_items / 2) offer_sample(next_sample(), 1'b0, '0);
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial
    begin
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = '0;
        cfg_data            = '0;
        sample_ch.valid     = 1'b0;
        sample_ch.sample_in = '0;
        row_typed           = 1'b0;
        row_want            = '0;
        src_idle_pct        = 0;
        sink_stall_pct      = 0;
        hold_armed          = 1'b0;
        mismatch_count      = 0;

        thr_reg   = THR_W'(spg_pkg::THRESHOLD_RST);
        pw_reg    = PW_W'(spg_pkg::PULSE_WIDTH_RST);
        trig_hi   = 1'b0;
        elapsed_t = '0;
        prev_smp  = '0;

        wave_val   = 0;
        wave_goal  = 0;
        wave_step  = 1;
        wave_sign  = 1;
        burst_left = 0;
        burst_mode = 0;

        // Directed rows, from reset defaults (threshold 3, width 12 samples).
        row_smp_exp(16'sd0, PULSE_HI);             // no crossing yet, still inside width
        row_smp(SMP_MAX);                          // full-scale crossing
        row_smp(SMP_MIN);                          // trigger cleared
        row_wr(spg_pkg::CFG_PULSE_WIDTH, '0);      // zero width, mid pulse: overdue edge
        row_smp(-16'sd1);
        row_smp(16'sd5);                           // crossing and falling edge in one beat
        row_smp_exp(16'sd100, PULSE_LO);           // counter saturated: off
        row_wr(spg_pkg::CFG_PULSE_WIDTH, CFG_W'(PW_MAX));
        row_smp_exp(16'sd200, PULSE_LO);           // still off
        row_smp_exp(-16'sd4, PULSE_LO);            // trigger cleared, still off
        row_smp(16'sd4);                           // crossing, small fraction
        row_smp(SMP_MIN);
        row_wr(spg_pkg::CFG_THRESHOLD, 24'hFF8000); // zero threshold, junk above field
        row_smp(16'sd0);
        row_smp(16'sd1);                           // divisor not above numerator
        row_wr(spg_pkg::CFG_THRESHOLD, CFG_W'(THR_MAX));
        row_smp(SMP_MAX);
        row_smp(SMP_MIN);                          // only the minimum clears at max threshold
        row_smp(SMP_MAX);                          // maximum cannot cross
        row_wr(spg_pkg::CFG_THRESHOLD, 24'd2000);
        row_smp(16'sd1500);
        row_wr(spg_pkg::CFG_THRESHOLD, 24'd500);   // lower it under the previous sample
        row_smp_exp(16'sd1200, PULSE_HI);          // fraction clamps to one

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_table[i])
        begin
            if (stim_table[i].kind == ROW_WRITE)
                write_reg(stim_table[i].idx, stim_table[i].val);
            else
                offer_sample(stim_table[i].smp, stim_table[i].typed, stim_table[i].want);
        end

        // random part under the idling patterns
        run_phase(0, 0, 100);
        run_phase(71, 0, 100);
        run_phase(0, 71, 100);
        run_phase(9, 9, 100);

        // long receiver hold-off while samples keep coming: back-pressure
        shuffle_config();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_armed     = 1'b1;
        repeat (60) offer_sample(next_sample(), 1'b0, '0);

        run_phase(0, 0, 50);

        settle_idle();
        repeat (END_PAUSE) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS schmitt_pwm_pulse_generator");
        else
            $display("FAIL schmitt_pwm_pulse_generator");
        $finish;
    end

endmodule
